/* hw/rtl/y86_pkg.sv */
`timescale 1ns / 1ps

package y86_pkg;

   localparam int MEM_BYTES = 8192;
   localparam int NUM_REGS  = 15;
   localparam int ADDR_W    = 13;
   localparam int ROWS      = MEM_BYTES / 8;
   localparam int ROW_W     = $clog2(ROWS);

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_HLT = 2'd1;
   localparam logic [1:0] ST_ADR = 2'd2;
   localparam logic [1:0] ST_INS = 2'd3;

   localparam logic [3:0] REG_SP   = 4'h4;
   localparam logic [3:0] REG_NONE = 4'hF;

   localparam logic [3:0] IC_HALT  = 4'h0;
   localparam logic [3:0] IC_NOP   = 4'h1;
   localparam logic [3:0] IC_CMOV  = 4'h2;
   localparam logic [3:0] IC_IRMOV = 4'h3;
   localparam logic [3:0] IC_RMMOV = 4'h4;
   localparam logic [3:0] IC_MRMOV = 4'h5;
   localparam logic [3:0] IC_OP    = 4'h6;
   localparam logic [3:0] IC_JXX   = 4'h7;
   localparam logic [3:0] IC_CALL  = 4'h8;
   localparam logic [3:0] IC_RET   = 4'h9;
   localparam logic [3:0] IC_PUSH  = 4'hA;
   localparam logic [3:0] IC_POP   = 4'hB;
   localparam logic [3:0] IC_IADD  = 4'hC;

   localparam logic [3:0] FN_ADD = 4'h0;
   localparam logic [3:0] FN_SUB = 4'h1;
   localparam logic [3:0] FN_AND = 4'h2;
   localparam logic [3:0] FN_XOR = 4'h3;

   function automatic logic [3:0] instr_len(input logic [3:0] icode);
      case (icode)
         IC_HALT, IC_NOP, IC_RET: instr_len = 4'd1;
         IC_CMOV, IC_OP, IC_PUSH, IC_POP: instr_len = 4'd2;
         IC_IRMOV, IC_RMMOV, IC_MRMOV, IC_IADD: instr_len = 4'd10;
         IC_JXX, IC_CALL: instr_len = 4'd9;
         default: instr_len = 4'd1;
      endcase
   endfunction

endpackage

/* hw/rtl/y86_bmem.sv */
`timescale 1ns / 1ps

module y86_bmem (
   input  logic                       clock,
   input  logic [y86_pkg::ADDR_W-1:0] rd_addr,
   output logic [63:0]                rd_word,
   input  logic                       wr_en,
   input  logic [y86_pkg::ADDR_W-1:0] wr_addr,
   input  logic [63:0]                wr_data,
   input  logic [7:0]                 wr_mask
);
   import y86_pkg::*;

   logic [7:0] lane_q [8];
   logic [2:0] rd_lo_ff;

   for (genvar b = 0; b < 8; b++) begin : g_bank
      logic [7:0]      bank [ROWS];
      logic [2:0]      rk;
      logic [2:0]      wk;
      logic [ADDR_W:0] rsum;
      logic [ADDR_W:0] wsum;

      assign rk   = 3'(b) - rd_addr[2:0];
      assign wk   = 3'(b) - wr_addr[2:0];
      assign rsum = {1'b0, rd_addr} + {{(ADDR_W - 2){1'b0}}, rk};
      assign wsum = {1'b0, wr_addr} + {{(ADDR_W - 2){1'b0}}, wk};

      always_ff @(posedge clock) begin
         if (wr_en && wr_mask[wk]) begin
            bank[wsum[ROW_W+2:3]] <= wr_data[{wk, 3'b000} +: 8];
         end
         lane_q[b] <= bank[rsum[ROW_W+2:3]];
      end
   end

   always_ff @(posedge clock) begin
      rd_lo_ff <= rd_addr[2:0];
   end

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         rd_word[8*k +: 8] = lane_q[3'(rd_lo_ff + 3'(k))];
      end
   end

endmodule

/* hw/rtl/y86_sequential_cpu_step.sv */
`timescale 1ns / 1ps
// A load transfer goes from acceptance to S_FIN, which registers the result; an execute
// transfer steps through S_F1, S_F2 and S_FIN, with S_DATA before S_FIN when it reads a data
// word (mrmovq, ret, popq). A faulting fetch ends in S_FIN after S_F1; an out-of-range PC or a
// stopped machine goes straight to S_FIN. A new transfer is accepted once the previous result
// is registered. After reset, a clearing pass zeroes MEM_BYTES/8 (1024) rows, one row a cycle,
// during which no transfer is accepted. Registers, PC, flags and status reset at once.

module y86_sequential_cpu_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [12:0]         req_load_address,
   input  logic [7:0]          req_load_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [63:0]         rsp_next_pc,
   output logic [1:0]          rsp_status,
   output logic                rsp_zero_flag,
   output logic                rsp_sign_flag,
   output logic                rsp_overflow_flag,
   output logic                rsp_reg_written,
   output logic [3:0]          rsp_reg_index,
   output logic signed [63:0]  rsp_reg_value,
   output logic [63:0]         rsp_stack_pointer,
   output logic                rsp_mem_written,
   output logic [12:0]         rsp_mem_address,
   output logic signed [63:0]  rsp_mem_value
);
   import y86_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_F1    = 3'd2;
   localparam logic [2:0] S_F2    = 3'd3;
   localparam logic [2:0] S_DATA  = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;

   localparam logic [63:0] MEM_SIZE = 64'(MEM_BYTES);

   logic [2:0]  state_ff, state_in;
   logic [ROW_W-1:0] clr_ff, clr_in;
   logic [63:0] pc_ff, pc_in, sp_ff, sp_in, valp_ff, valp_in;
   logic [1:0]  status_ff, status_in;
   logic        zf_ff, zf_in, sf_ff, sf_in, of_ff, of_in;
   logic [3:0]  icode_ff, icode_in, ifun_ff, ifun_in, ra_ff, ra_in, rb_ff, rb_in;
   logic        res_rw_ff, res_rw_in, res_mw_ff, res_mw_in;
   logic [3:0]  res_widx_ff, res_widx_in;
   logic [63:0] res_wval_ff, res_wval_in, res_mval_ff, res_mval_in;
   logic [12:0] res_maddr_ff, res_maddr_in;
   logic        rsp_valid_ff;

   logic [63:0] rf_mem [NUM_REGS];
   logic        rf_valid_ff [NUM_REGS];
   logic [63:0] rf_a_ff, rf_b_ff;

   logic [ADDR_W-1:0] mem_rd_addr, mem_wr_addr;
   logic [63:0] mem_rd_word, mem_wr_data;
   logic        mem_wr_en;
   logic [7:0]  mem_wr_mask;

   logic        wb_en;
   logic [3:0]  wb_idx;
   logic [63:0] wb_val;

   logic [3:0]  f_icode, f_len;
   logic [63:0] reg_a, reg_b, addr_sum, sp_dec, alu_r;
   logic        alu_of, cond;

   function automatic logic cond_true(input logic [3:0] fn, input logic zf, input logic sf,
                                      input logic of);
      logic lt;
      lt = sf ^ of;
      case (fn)
         4'h0: cond_true = 1'b1;
         4'h1: cond_true = lt | zf;
         4'h2: cond_true = lt;
         4'h3: cond_true = zf;
         4'h4: cond_true = ~zf;
         4'h5: cond_true = ~lt;
         4'h6: cond_true = ~lt & ~zf;
         default: cond_true = 1'b0;
      endcase
   endfunction

   y86_bmem u_mem (
      .clock   (clock),
      .rd_addr (mem_rd_addr),
      .rd_word (mem_rd_word),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .wr_mask (mem_wr_mask)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign f_icode   = mem_rd_word[7:4];
   assign f_len     = instr_len(f_icode);

   assign reg_a = (ra_ff == REG_NONE) ? 64'd0 : (ra_ff == REG_SP) ? sp_ff : rf_a_ff;
   assign reg_b = (rb_ff == REG_NONE) ? 64'd0 : (rb_ff == REG_SP) ? sp_ff : rf_b_ff;
   assign addr_sum = mem_rd_word + reg_b;
   assign sp_dec   = sp_ff - 64'd8;
   assign cond     = cond_true(ifun_ff, zf_ff, sf_ff, of_ff);

   always_comb begin
      alu_r  = 64'd0;
      alu_of = 1'b0;
      if (icode_ff == IC_IADD) begin
         alu_r  = reg_b + mem_rd_word;
         alu_of = (reg_b[63] == mem_rd_word[63]) && (alu_r[63] != reg_b[63]);
      end else begin
         case (ifun_ff)
            FN_ADD: begin
               alu_r  = reg_b + reg_a;
               alu_of = (reg_a[63] == reg_b[63]) && (alu_r[63] != reg_a[63]);
            end
            FN_SUB: begin
               alu_r  = reg_b - reg_a;
               alu_of = (reg_a[63] != reg_b[63]) && (alu_r[63] != reg_b[63]);
            end
            FN_AND: alu_r = reg_a & reg_b;
            FN_XOR: alu_r = reg_a ^ reg_b;
            default: alu_r = 64'd0;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pc_in        = pc_ff;
      sp_in        = sp_ff;
      valp_in      = valp_ff;
      status_in    = status_ff;
      zf_in        = zf_ff;
      sf_in        = sf_ff;
      of_in        = of_ff;
      icode_in     = icode_ff;
      ifun_in      = ifun_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      res_rw_in    = res_rw_ff;
      res_widx_in  = res_widx_ff;
      res_wval_in  = res_wval_ff;
      res_mw_in    = res_mw_ff;
      res_maddr_in = res_maddr_ff;
      res_mval_in  = res_mval_ff;
      mem_rd_addr  = pc_ff[ADDR_W-1:0];
      mem_wr_en    = 1'b0;
      mem_wr_addr  = {clr_ff, 3'b000};
      mem_wr_data  = 64'd0;
      mem_wr_mask  = 8'hFF;
      wb_en        = 1'b0;
      wb_idx       = REG_NONE;
      wb_val       = 64'd0;

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ROW_W'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               res_rw_in    = 1'b0;
               res_widx_in  = 4'd0;
               res_wval_in  = 64'd0;
               res_mw_in    = 1'b0;
               res_maddr_in = 13'd0;
               res_mval_in  = 64'd0;
               state_in     = S_FIN;
               if (!req_kind) begin
                  mem_wr_en   = (32'(req_load_address) < MEM_BYTES);
                  mem_wr_addr = ADDR_W'(req_load_address);
                  mem_wr_data = {56'd0, req_load_byte};
                  mem_wr_mask = 8'h01;
               end else if (status_ff == ST_OK) begin
                  if (pc_ff >= MEM_SIZE) begin
                     status_in = ST_ADR;
                  end else begin
                     state_in = S_F1;
                  end
               end
            end
         end
         S_F1: begin
            icode_in = f_icode;
            ifun_in  = mem_rd_word[3:0];
            valp_in  = pc_ff + 64'(f_len);
            if (f_len >= 4'd2 && f_len != 4'd9) begin
               ra_in = mem_rd_word[15:12];
               rb_in = mem_rd_word[11:8];
            end else begin
               ra_in = REG_NONE;
               rb_in = REG_NONE;
            end
            mem_rd_addr = pc_ff[ADDR_W-1:0] + ((f_len == 4'd9) ? ADDR_W'(1) : ADDR_W'(2));
            if (f_icode > IC_IADD) begin
               status_in = ST_INS;
               state_in  = S_FIN;
            end else if (64'(f_len) > MEM_SIZE - pc_ff) begin
               status_in = ST_ADR;
               state_in  = S_FIN;
            end else begin
               state_in = S_F2;
            end
         end
         S_F2: begin
            state_in = S_FIN;
            case (icode_ff)
               IC_HALT: status_in = ST_HLT;
               IC_NOP: pc_in = valp_ff;
               IC_CMOV: begin
                  pc_in = valp_ff;
                  if (cond && rb_ff != REG_NONE) begin
                     wb_en = 1'b1; wb_idx = rb_ff; wb_val = reg_a;
                  end
               end
               IC_IRMOV: begin
                  pc_in = valp_ff;
                  if (rb_ff != REG_NONE) begin
                     wb_en = 1'b1; wb_idx = rb_ff; wb_val = mem_rd_word;
                  end
               end
               IC_RMMOV, IC_MRMOV: begin
                  mem_rd_addr = addr_sum[ADDR_W-1:0];
                  if (addr_sum > MEM_SIZE - 64'd8) begin
                     status_in = ST_ADR;
                  end else if (icode_ff == IC_RMMOV) begin
                     pc_in       = valp_ff;
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = addr_sum[ADDR_W-1:0];
                     mem_wr_data = reg_a;
                  end else begin
                     state_in = S_DATA;
                  end
               end
               IC_OP, IC_IADD: begin
                  if (icode_ff == IC_OP && ifun_ff > FN_XOR) begin
                     status_in = ST_INS;
                  end else begin
                     pc_in = valp_ff;
                     zf_in = (alu_r == 64'd0);
                     sf_in = alu_r[63];
                     of_in = alu_of;
                     if (rb_ff != REG_NONE) begin
                        wb_en = 1'b1; wb_idx = rb_ff; wb_val = alu_r;
                     end
                  end
               end
               IC_JXX: pc_in = cond ? mem_rd_word : valp_ff;
               IC_CALL, IC_PUSH: begin
                  if (sp_dec > MEM_SIZE - 64'd8) begin
                     status_in = ST_ADR;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = sp_dec[ADDR_W-1:0];
                     mem_wr_data = (icode_ff == IC_CALL) ? valp_ff : reg_a;
                     sp_in       = sp_dec;
                     pc_in       = (icode_ff == IC_CALL) ? mem_rd_word : valp_ff;
                  end
               end
               IC_RET, IC_POP: begin
                  mem_rd_addr = sp_ff[ADDR_W-1:0];
                  if (sp_ff > MEM_SIZE - 64'd8) begin
                     status_in = ST_ADR;
                  end else begin
                     state_in = S_DATA;
                  end
               end
               default: status_in = ST_INS;
            endcase
            if (mem_wr_en) begin
               res_mw_in    = 1'b1;
               res_maddr_in = 13'(mem_wr_addr);
               res_mval_in  = mem_wr_data;
            end
         end
         S_DATA: begin
            state_in = S_FIN;
            if (icode_ff == IC_RET) begin
               pc_in = mem_rd_word;
               sp_in = sp_ff + 64'd8;
            end else begin
               pc_in = valp_ff;
               if (icode_ff == IC_POP) begin
                  sp_in = sp_ff + 64'd8;
               end
               if (ra_ff != REG_NONE) begin
                  wb_en = 1'b1; wb_idx = ra_ff; wb_val = mem_rd_word;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (wb_en) begin
         res_rw_in   = 1'b1;
         res_widx_in = wb_idx;
         res_wval_in = wb_val;
         if (wb_idx == REG_SP) begin
            sp_in = wb_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= 64'd0;
         sp_ff        <= 64'd0;
         status_ff    <= ST_OK;
         zf_ff        <= 1'b1;
         sf_ff        <= 1'b0;
         of_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            rf_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         pc_ff     <= pc_in;
         sp_ff     <= sp_in;
         status_ff <= status_in;
         zf_ff     <= zf_in;
         sf_ff     <= sf_in;
         of_ff     <= of_in;
         if (wb_en && wb_idx != REG_SP) begin
            rf_valid_ff[wb_idx] <= 1'b1;
         end
         if (state_ff == S_FIN && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      valp_ff      <= valp_in;
      icode_ff     <= icode_in;
      ifun_ff      <= ifun_in;
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      res_rw_ff    <= res_rw_in;
      res_widx_ff  <= res_widx_in;
      res_wval_ff  <= res_wval_in;
      res_mw_ff    <= res_mw_in;
      res_maddr_ff <= res_maddr_in;
      res_mval_ff  <= res_mval_in;
      if (wb_en && wb_idx != REG_SP) begin
         rf_mem[wb_idx] <= wb_val;
      end
      if (state_ff == S_F1) begin
         rf_a_ff <= (ra_in != REG_NONE && rf_valid_ff[ra_in]) ? rf_mem[ra_in] : 64'd0;
         rf_b_ff <= (rb_in != REG_NONE && rf_valid_ff[rb_in]) ? rf_mem[rb_in] : 64'd0;
      end
      if (state_ff == S_FIN && (!rsp_valid_ff || rsp_ready)) begin
         rsp_next_pc       <= pc_ff;
         rsp_status        <= status_ff;
         rsp_zero_flag     <= zf_ff;
         rsp_sign_flag     <= sf_ff;
         rsp_overflow_flag <= of_ff;
         rsp_reg_written   <= res_rw_ff;
         rsp_reg_index     <= res_widx_ff;
         rsp_reg_value     <= res_wval_ff;
         rsp_stack_pointer <= sp_ff;
         rsp_mem_written   <= res_mw_ff;
         rsp_mem_address   <= res_maddr_ff;
         rsp_mem_value     <= res_mval_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_fetch_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_F1) |-> (status_ff == ST_OK))
      else $error("Fetch started on a stopped machine.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("Accepted transfer did not start.");

   a_store_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && res_mw_ff) |-> (32'(res_maddr_ff) <= MEM_BYTES - 8))
      else $error("Stored word exceeds memory.");

   a_wb_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && res_rw_ff) |-> (res_widx_ff != REG_NONE))
      else $error("Register write to the empty register code.");

endmodule
